/* rtl/core/i2r_pkg.sv */
// shared constants, tables and command/status types for the roman numeral encoder
`default_nettype none

package i2r_pkg;

    localparam int NUMBER_W = 12;
    localparam int LETTER_W = 7;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 2;
    localparam int KIDX_W   = 2;
    localparam int LEN_W    = 3;
    localparam int STEP_W   = 14;

    localparam logic [NUMBER_W-1:0] MAX_VALID = 12'd3999;
    localparam logic [POS_W-1:0]    POS_TOP   = 2'd3;

    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] LETTER_I    = 7'h49;
    localparam logic [LETTER_W-1:0] LETTER_V    = 7'h56;
    localparam logic [LETTER_W-1:0] LETTER_X    = 7'h58;
    localparam logic [LETTER_W-1:0] LETTER_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] LETTER_C    = 7'h43;
    localparam logic [LETTER_W-1:0] LETTER_D    = 7'h44;
    localparam logic [LETTER_W-1:0] LETTER_M    = 7'h4D;

    // multiples of each decimal weight, ones up to thousands
    localparam logic [STEP_W-1:0] STEP_TABLE [4][10] = '{
        '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9},
        '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40, 14'd50, 14'd60, 14'd70, 14'd80,
          14'd90},
        '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700,
          14'd800, 14'd900},
        '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000,
          14'd7000, 14'd8000, 14'd9000}
    };

    typedef struct packed {
        logic load;
        logic digit;
        logic emit;
        logic emit_bad;
    } i2r_cmd_t;

    typedef struct packed {
        logic bad;
        logic digit_zero;
        logic group_done;
        logic final_group;
    } i2r_status_t;

    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] len;
        case (d)
            4'd1, 4'd5:        len = 3'd1;
            4'd2, 4'd4, 4'd6:  len = 3'd2;
            4'd9:              len = 3'd2;
            4'd3, 4'd7:        len = 3'd3;
            4'd8:              len = 3'd4;
            default:           len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(
        input logic [POS_W-1:0]   pos,
        input logic [DIGIT_W-1:0] d,
        input logic [KIDX_W-1:0]  k
    );
        logic [LETTER_W-1:0] u;
        logic [LETTER_W-1:0] f;
        logic [LETTER_W-1:0] t;
        logic [LETTER_W-1:0] res;
        case (pos)
            2'd0:
            begin
                u = LETTER_I; f = LETTER_V; t = LETTER_X;
            end
            2'd1:
            begin
                u = LETTER_X; f = LETTER_L; t = LETTER_C;
            end
            2'd2:
            begin
                u = LETTER_C; f = LETTER_D; t = LETTER_M;
            end
            default:
            begin
                u = LETTER_M; f = LETTER_NONE; t = LETTER_NONE;
            end
        endcase
        if (d == 4'd9)
        begin
            res = (k == 2'd0) ? u : t;
        end
        else if (d == 4'd4)
        begin
            res = (k == 2'd0) ? u : f;
        end
        else if (d >= 4'd5)
        begin
            res = (k == 2'd0) ? f : u;
        end
        else
        begin
            res = u;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/i2r_in_if.sv */
// request channel: the number to convert
`default_nettype none

interface i2r_in_if;
    logic                               valid;
    logic                               ready;
    logic [i2r_pkg::NUMBER_W-1:0]       number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2r_out_if.sv */
// result channel: one roman letter per transaction
`default_nettype none

interface i2r_out_if;
    logic                               valid;
    logic                               ready;
    logic [i2r_pkg::LETTER_W-1:0]       letter;
    logic                               last_letter;
    logic                               invalid;

    modport source (output valid, output letter, output last_letter, output invalid,
                    input ready);
    modport sink   (input valid, input letter, input last_letter, input invalid,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/integer_to_roman_encoder.sv */
// Integer to Roman numeral encoder, top level.
//
// request carries a 12-bit unsigned number; result returns its Roman numeral
// as 7-bit ASCII letters, most significant first, one letter per transaction,
// with last_letter set on the final letter. A number of 0 or above 3999 gives
// a single transaction with invalid and last_letter set and letter 0.
//
// After a request transaction with a valid number the block walks the decimal
// positions, thousands first, finding one position's digit per cycle between letter
// groups, and writes each nonzero digit's letters into the output register, one
// letter per cycle while that register is free; the walk stops once the remainder
// is zero. The longest numeral, for 3888, has fifteen letters.
// request.ready is high only while no number is in progress; it returns the
// cycle after the last letter is written, even if that letter still waits.
// If the receiver holds result.ready low, the current letter stays put and
// conversion pauses until it is taken.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns the controller to idle; no result is pending afterwards.
`default_nettype none

module integer_to_roman_encoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    i2r_in_if.sink     request,
    i2r_out_if.source  result
);

    i2r_pkg::i2r_cmd_t    cmd;
    i2r_pkg::i2r_status_t status;

    i2r_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .cmd       (cmd),
        .status    (status)
    );

    i2r_datapath u_datapath (
        .clk         (clk),
        .number      (request.number),
        .cmd         (cmd),
        .status      (status),
        .letter      (result.letter),
        .last_letter (result.last_letter),
        .invalid     (result.invalid)
    );

    // an invalid number is always a single, empty transaction
    a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.invalid
        |-> result.last_letter && (result.letter == i2r_pkg::LETTER_NONE))
        else $error("invalid result not flagged last or carries a letter");

    // no new number while one is in progress
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("request accepted twice back to back");

    // a letter that is not the last means the numeral is still being produced
    a_busy_mid_numeral: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last_letter |-> !request.ready)
        else $error("ready for a new number before the numeral finished");

endmodule

`default_nettype wire

/* rtl/core/i2r_datapath.sv */
// datapath: digit extraction one decimal position a cycle while cmd.digit is set, letter lookup, output payload
`default_nettype none

module i2r_datapath (
    input  wire logic                          clk,
    input  wire logic [i2r_pkg::NUMBER_W-1:0]  number,
    input  wire i2r_pkg::i2r_cmd_t             cmd,
    output i2r_pkg::i2r_status_t               status,
    output logic [i2r_pkg::LETTER_W-1:0]       letter,
    output logic                               last_letter,
    output logic                               invalid
);

    logic [i2r_pkg::NUMBER_W-1:0] rem_reg;
    logic [i2r_pkg::NUMBER_W-1:0] rem_next;
    logic [i2r_pkg::POS_W-1:0]    pos_reg;
    logic [i2r_pkg::POS_W-1:0]    pos_next;
    logic [i2r_pkg::DIGIT_W-1:0]  digit_reg;
    logic [i2r_pkg::DIGIT_W-1:0]  digit_next;
    logic [i2r_pkg::KIDX_W-1:0]   k_reg;
    logic [i2r_pkg::KIDX_W-1:0]   k_next;
    logic                         bad_reg;
    logic                         bad_next;
    logic [i2r_pkg::LETTER_W-1:0] letter_reg;
    logic [i2r_pkg::LETTER_W-1:0] letter_next;
    logic                         last_reg;
    logic                         last_next;
    logic                         invalid_reg;
    logic                         invalid_next;

    logic [i2r_pkg::DIGIT_W-1:0]  digit_calc;
    logic [i2r_pkg::NUMBER_W-1:0] rem_sub;
    logic                         group_done;
    logic                         final_group;

    // digit of the current position: count of multiples that fit, all compares in parallel
    always_comb
    begin
        digit_calc = '0;
        for (int j = 1; j < 10; j++)
        begin
            if ({2'b00, rem_reg} >= i2r_pkg::STEP_TABLE[pos_reg][j])
            begin
                digit_calc = digit_calc + 4'd1;
            end
        end
        rem_sub = rem_reg - i2r_pkg::STEP_TABLE[pos_reg][digit_calc][i2r_pkg::NUMBER_W-1:0];
    end

    assign group_done  = ((3'(k_reg) + 3'd1) == i2r_pkg::digit_len(digit_reg));
    // lower positions are all zero once the remainder is gone
    assign final_group = (rem_reg == '0);

    always_comb
    begin
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        digit_next   = digit_reg;
        k_next       = k_reg;
        bad_next     = bad_reg;
        letter_next  = letter_reg;
        last_next    = last_reg;
        invalid_next = invalid_reg;
        if (cmd.load)
        begin
            rem_next = number;
            pos_next = i2r_pkg::POS_TOP;
            bad_next = (number == '0) || (number > i2r_pkg::MAX_VALID);
        end
        if (cmd.digit)
        begin
            digit_next = digit_calc;
            rem_next   = rem_sub;
            k_next     = '0;
            if (digit_calc == '0)
            begin
                pos_next = pos_reg - 2'd1;
            end
        end
        if (cmd.emit)
        begin
            letter_next  = i2r_pkg::letter_of(pos_reg, digit_reg, k_reg);
            last_next    = group_done && final_group;
            invalid_next = 1'b0;
            k_next       = k_reg + 2'd1;
            if (group_done)
            begin
                pos_next = pos_reg - 2'd1;
            end
        end
        if (cmd.emit_bad)
        begin
            letter_next  = i2r_pkg::LETTER_NONE;
            last_next    = 1'b1;
            invalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        pos_reg     <= pos_next;
        digit_reg   <= digit_next;
        k_reg       <= k_next;
        bad_reg     <= bad_next;
        letter_reg  <= letter_next;
        last_reg    <= last_next;
        invalid_reg <= invalid_next;
    end

    assign status.bad         = bad_reg;
    assign status.digit_zero  = (digit_calc == '0);
    assign status.group_done  = group_done;
    assign status.final_group = final_group;

    assign letter      = letter_reg;
    assign last_letter = last_reg;
    assign invalid     = invalid_reg;

endmodule

`default_nettype wire

/* rtl/core/i2r_ctrl.sv */
// controller: sequences load, digit and letter steps and owns the output valid flag
`default_nettype none

module i2r_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output i2r_pkg::i2r_cmd_t      cmd,
    input  wire i2r_pkg::i2r_status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIGIT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // output register is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.bad)
                begin
                    if (slot_free)
                    begin
                        cmd.emit_bad   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.digit = 1'b1;
                    if (!status.digit_zero)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.group_done)
                    begin
                        state_next = status.final_group ? ST_IDLE : ST_DIGIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* sim/integer_to_roman_encoder_checker.sv */
`timescale 1ns / 100ps
// checker that predicts the roman numeral letters of each number and compares the result channel
module integer_to_roman_encoder_checker (
    input  logic clk,
    i2r_in_if    request,
    i2r_out_if   result,
    output int   fail_count,
    output int   expected_count
);

    typedef struct packed {
        logic [i2r_pkg::LETTER_W-1:0] letter;
        logic                         last_letter;
        logic                         invalid;
    } numeral_letter_t;

    numeral_letter_t numeral_letters[$];
    int mismatches = 0;

    // spells one number, thousands first, and queues its letters
    function automatic void spell_numeral(input logic [i2r_pkg::NUMBER_W-1:0] value);
        logic [i2r_pkg::LETTER_W-1:0] spelled [15];
        logic [i2r_pkg::LETTER_W-1:0] one_l;
        logic [i2r_pkg::LETTER_W-1:0] five_l;
        logic [i2r_pkg::LETTER_W-1:0] ten_l;
        numeral_letter_t entry;
        int count;
        int num;
        int weight;
        int digit;
        count  = 0;
        num    = int'(value);
        weight = 1000;
        if (value == '0 || value > i2r_pkg::MAX_VALID)
        begin
            entry = '{i2r_pkg::LETTER_NONE, 1'b1, 1'b1};
            numeral_letters.insert(numeral_letters.size(), entry);
            return;
        end
        for (int pos = 3; pos >= 0; pos--)
        begin
            digit = (num / weight) % 10;
            case (pos)
                0:
                begin
                    one_l = i2r_pkg::LETTER_I; five_l = i2r_pkg::LETTER_V;
                    ten_l = i2r_pkg::LETTER_X;
                end
                1:
                begin
                    one_l = i2r_pkg::LETTER_X; five_l = i2r_pkg::LETTER_L;
                    ten_l = i2r_pkg::LETTER_C;
                end
                2:
                begin
                    one_l = i2r_pkg::LETTER_C; five_l = i2r_pkg::LETTER_D;
                    ten_l = i2r_pkg::LETTER_M;
                end
                default:
                begin
                    one_l = i2r_pkg::LETTER_M; five_l = i2r_pkg::LETTER_NONE;
                    ten_l = i2r_pkg::LETTER_NONE;
                end
            endcase
            if (digit == 9)
            begin
                spelled[count]     = one_l;
                spelled[count + 1] = ten_l;
                count = count + 2;
            end
            else if (digit == 4)
            begin
                spelled[count]     = one_l;
                spelled[count + 1] = five_l;
                count = count + 2;
            end
            else
            begin
                if (digit >= 5)
                begin
                    spelled[count] = five_l;
                    count = count + 1;
                    digit = digit - 5;
                end
                repeat (digit)
                begin
                    spelled[count] = one_l;
                    count = count + 1;
                end
            end
            weight = weight / 10;
        end
        for (int k = 0; k < count; k++)
        begin
            entry = '{spelled[k], k == count - 1, 1'b0};
            numeral_letters.insert(numeral_letters.size(), entry);
        end
    endfunction

    always @(posedge clk)
    begin : compare_letters
        numeral_letter_t want;
        // results are taken before the new number is queued
        if (result.valid && result.ready)
        begin
            if (numeral_letters.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected letter %h last %b invalid %b", $time,
                             result.letter, result.last_letter, result.invalid);
            end
            else
            begin
                want = numeral_letters.pop_front();
                if (result.letter !== want.letter || result.last_letter !== want.last_letter
                    || result.invalid !== want.invalid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: letter %h/%h last %b/%b invalid %b/%b (expected/actual)",
                                 $time, want.letter, result.letter, want.last_letter,
                                 result.last_letter, want.invalid, result.invalid);
                end
            end
        end
        if (request.valid && request.ready)
            spell_numeral(request.number);
        fail_count     <= mismatches;
        expected_count <= numeral_letters.size();
    end

endmodule

/* sim/integer_to_roman_encoder_tb.sv */
`timescale 1ns / 100ps
// testbench top: clock, reset, number stimulus, letter receiver and verdict for the encoder
module integer_to_roman_encoder_tb;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 600;
    localparam int RANDOM_NUMBERS  = 445;
    localparam int DRAIN_AT        = 150;

    // extremes, many digit values in each position, longest numeral
    localparam logic [i2r_pkg::NUMBER_W-1:0] DIRECTED [25] = '{
        12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9, 12'd5,
        12'd8, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd2000, 12'd3000,
        12'd444, 12'd999, 12'd1994, 12'd2048, 12'd1024, 12'd3, 12'd14, 12'd2767
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   expected_count;
    int   quiet_cycles = 0;
    int   letters_taken = 0;
    logic sender_gaps = 1'b1;
    logic receiver_stalls = 1'b1;

    i2r_in_if  request_ch();
    i2r_out_if result_ch();

    integer_to_roman_encoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    integer_to_roman_encoder_checker i_checker (
        .clk            (clk),
        .request        (request_ch),
        .result         (result_ch),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_number(input logic [i2r_pkg::NUMBER_W-1:0] value);
        int gap;
        gap = sender_gaps ? $urandom_range(17, 0) : 0;
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid  <= 1'b1;
        request_ch.number <= value;
        @(posedge clk);
        while (!(request_ch.valid && request_ch.ready)) @(posedge clk);
    endtask

    initial
    begin
        int value;
        int pick;
        rst_n             <= 1'b0;
        request_ch.valid  <= 1'b0;
        request_ch.number <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED[i])
            send_number(DIRECTED[i]);
        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            if (i % 32 == 0)
                sender_gaps = ($urandom_range(3, 0) != 0);
            if (i == DRAIN_AT)
            begin
                // let every letter come out before going on
                request_ch.valid <= 1'b0;
                @(posedge clk);
                while (expected_count != 0) @(posedge clk);
            end
            pick = $urandom_range(19, 0);
            if (pick == 0)
                value = $urandom_range(1, 0) ? 0 : $urandom_range(4095, 4000);
            else if (pick <= 2)
                value = $urandom_range(4095, 0);
            else
                value = $urandom_range(3999, 1);
            send_number(value[i2r_pkg::NUMBER_W-1:0]);
        end
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("integer_to_roman_encoder_tb OK");
        else
            $display("integer_to_roman_encoder_tb NOT OK");
        $finish;
    end

    // letter receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (letters_taken % 64 == 0)
                receiver_stalls = ($urandom_range(3, 0) != 0);
            if (letters_taken == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else
                stall = receiver_stalls ? $urandom_range(17, 0) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
            letters_taken++;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("integer_to_roman_encoder_tb NOT OK");
            $finish;
        end
    end

endmodule
